/* rtl/assert_macros.svh */
// Assertion macros used by the checker module gcd_chk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that also holds across reset.
`define CHK_NEXT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* rtl/gcd_pkg.sv */
`default_nettype none

package gcd_pkg;

  localparam int OPERAND_BITS = 31;
  localparam int DATA_W = ((OPERAND_BITS + 7) / 8) * 8;
  localparam int K_W = $clog2(OPERAND_BITS);

  typedef logic [OPERAND_BITS-1:0] operand_t;

endpackage

`default_nettype wire

/* rtl/gcd_of_stream_unit.sv */
// A single-item run goes from ST_IDLE to ST_FINISH, which hands the result to the output
// register once it is free. Each later request runs a binary gcd in one shared subtract
// and shift unit, one step per cycle.
// The unit takes one request at a time; the input is ready only between requests.
// Reset (rst, synchronous, active high) starts a new run and drops any pending result.
`default_nettype none

module gcd_of_stream_unit
  import gcd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [DATA_W-1:0] s_axis_tdata,   // operand
  input  wire logic              s_axis_tlast,   // last_item
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic [DATA_W-1:0]      m_axis_tdata,   // divisor
  output logic                   m_axis_tuser    // bad_operand
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_CALC   = 3'b010,
    ST_FINISH = 3'b100
  } state_t;

  state_t                state;
  operand_t              gcd;
  operand_t              a;
  operand_t              b;
  logic [K_W-1:0]        k;
  logic                  err;
  logic                  at_start;
  logic                  last_pend;
  logic                  out_valid;
  operand_t              out_data;
  logic                  out_err;

  operand_t              op;
  logic [OPERAND_BITS:0] diff;
  logic                  borrow;

  assign op            = s_axis_tdata[OPERAND_BITS-1:0];
  assign diff          = {1'b0, a} - {1'b0, b};
  assign borrow        = diff[OPERAND_BITS];
  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = DATA_W'(out_data);
  assign m_axis_tuser  = out_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      gcd       <= '0;
      err       <= 1'b0;
      at_start  <= 1'b1;
      last_pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            err       <= err | (op == '0);
            last_pend <= s_axis_tlast;
            at_start  <= 1'b0;
            if (at_start) begin
              gcd   <= op;
              state <= s_axis_tlast ? ST_FINISH : ST_IDLE;
            end else begin
              a     <= gcd;
              b     <= op;
              k     <= '0;
              state <= ST_CALC;
            end
          end
        end
        ST_CALC: begin
          priority if (a == '0 || b == '0) begin
            gcd   <= (a | b) << k;
            state <= last_pend ? ST_FINISH : ST_IDLE;
          end else if (!a[0] && !b[0]) begin
            a <= a >> 1;
            b <= b >> 1;
            k <= k + 1'b1;
          end else if (!a[0]) begin
            a <= a >> 1;
          end else if (!b[0]) begin
            b <= b >> 1;
          end else if (borrow) begin
            a <= b;
            b <= a;
          end else begin
            a <= diff[OPERAND_BITS-1:0];
          end
        end
        ST_FINISH: begin
          if (!out_valid || m_axis_tready) begin
            out_data  <= err ? '0 : gcd;
            out_err   <= err;
            out_valid <= 1'b1;
            gcd       <= '0;
            err       <= 1'b0;
            at_start  <= 1'b1;
            last_pend <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/gcd_chk.sv */
`default_nettype none

`include "assert_macros.svh"

module gcd_chk
  import gcd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [DATA_W-1:0] m_axis_tdata,
  input wire logic              m_axis_tuser
);

  `CHK_IMP(a_err_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0)
  `CHK_IMP(a_ok_nonzero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata != '0)
  `CHK_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `CHK_NEXT_RST(a_rst_clear, rst, !m_axis_tvalid)

endmodule

bind gcd_of_stream_unit gcd_chk u_gcd_chk (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
